### design/scb_pkg.sv
// ============================================================================
// scb_pkg
// Shared types and constants for the scrolling text console cell buffer.
// ============================================================================
`default_nettype none

package scb_pkg;

    // Request codes carried in tuser
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_ENDL  = 2'd1,
        REQ_BACK  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_FILL,
        ST_BACK,
        ST_MOD,
        ST_ADDR,
        ST_RDATA,
        ST_DONE
    } t_state;

    // Field widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned RGB_W   = 3 * COLOR_W;
    localparam int unsigned CELL_W  = CHAR_W + RGB_W;
    localparam int unsigned INDEX_W = 12;

    // Characters
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] NULL_CHAR  = 8'h00;

endpackage

`default_nettype wire

### design/scrolling_text_console_buffer.sv
// A write goes through ST_PUT to ST_DONE, with an ST_FILL pass over a row when the write scrolls.
// End line pads the rest of the row with spaces in ST_PUT, plus ST_FILL per scroll; backspace uses ST_BACK.
// Read: ST_MOD compare-subtract steps (one step at 80 x 45), then ST_ADDR and ST_RDATA for the RAM read.
// One transaction in flight; the next is taken while the result waits in the output register.
// After reset a clearing pass writes null cells to all ROWS*COLUMNS cells before
// the first transaction is accepted.
// ============================================================================
// scrolling_text_console_buffer
// Ring-organized text console cell store with cursor, scrolling and reads.
// ============================================================================
`default_nettype none

module scrolling_text_console_buffer
    import scb_pkg::*;
#(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 45
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: ch[7:0], color_red[15:8], color_green[23:16], color_blue[31:24],
    //        view_index[43:32], zero pad[47:44]
    input  wire logic [47:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: cell_char[7:0], cell_red[15:8], cell_green[23:16], cell_blue[31:24],
    //        cursor_pos[43:32], top_line_pos[55:44]
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    localparam int unsigned CC = ROWS * COLUMNS;
    localparam int unsigned PW = $clog2(CC);
    localparam int unsigned CW = $clog2(COLUMNS);
    localparam int unsigned DW = PW + INDEX_W;
    localparam int unsigned SW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;

    // Compare-subtract steps needed to bring any screen index below the cell count
    localparam int unsigned MAX_VIEW  = (1 << INDEX_W) - 1;
    localparam int unsigned VIEW_Q    = MAX_VIEW / CC;
    localparam int unsigned MOD_STEPS = (VIEW_Q == 0) ? 1 : $clog2(VIEW_Q + 1);

    localparam logic [PW-1:0] LAST_POS = PW'(CC - 1);
    localparam logic [PW-1:0] LAST_TOP = PW'(CC - COLUMNS);
    localparam logic [PW-1:0] COLS_P   = PW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [DW-1:0] DIV_INIT = DW'(CC) << (MOD_STEPS - 1);
    localparam logic [SW-1:0] CC_S     = SW'(CC);

    // Control registers
    t_state          r_state, n_state;
    logic [PW-1:0]   r_cursor, n_cursor;
    logic [CW-1:0]   r_col, n_col;
    logic [PW-1:0]   r_top, n_top;
    logic [PW-1:0]   r_clr, n_clr;
    logic [CW-1:0]   r_fcnt, n_fcnt;
    logic [3:0]      r_step, n_step;
    logic            r_out_valid, n_out_valid;

    // Payload registers
    t_req            r_req, n_req;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic [RGB_W-1:0]  r_rgb, n_rgb;
    logic [INDEX_W-1:0] r_rem, n_rem;
    logic [DW-1:0]   r_div, n_div;
    logic [CELL_W-1:0] r_cell, n_cell;
    logic [55:0]     r_out_data, n_out_data;

    // RAM port signals
    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // Helpers
    logic [PW-1:0]   cur_inc, cur_dec, top_inc;
    logic [CW-1:0]   col_inc, col_dec;
    logic            in_fire, out_free, scroll_hit, more_pad;
    logic [DW-1:0]   rem_ext;
    logic [SW-1:0]   addr_sum, addr_wrap;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Ring arithmetic
    assign cur_inc = (r_cursor == LAST_POS) ? '0 : r_cursor + PW'(1);
    assign cur_dec = (r_cursor == '0) ? LAST_POS : r_cursor - PW'(1);
    assign col_inc = (r_col == LAST_COL) ? '0 : r_col + CW'(1);
    assign col_dec = (r_col == '0) ? LAST_COL : r_col - CW'(1);
    assign top_inc = (r_top == LAST_TOP) ? '0 : r_top + COLS_P;

    // Scroll when the advanced cursor lands on the top line
    assign scroll_hit = (cur_inc == r_top);
    assign more_pad   = (r_req == REQ_ENDL) && (r_col != '0);

    // Screen index to ring address
    assign rem_ext   = DW'(r_rem);
    assign addr_sum  = SW'(r_rem) + SW'(r_top);
    assign addr_wrap = (addr_sum >= CC_S) ? addr_sum - CC_S : addr_sum;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_POS) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (t_req'(s_axis_tuser))
                        REQ_WRITE: n_state = ST_PUT;
                        REQ_ENDL:  n_state = (r_col == '0) ? ST_DONE : ST_PUT;
                        REQ_BACK:  n_state = ST_BACK;
                        REQ_READ:  n_state = ST_MOD;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_PUT: begin
                if (scroll_hit) begin
                    n_state = ST_FILL;
                end else if ((r_req == REQ_ENDL) && (col_inc != '0)) begin
                    n_state = ST_PUT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                if (r_fcnt == LAST_COL) n_state = more_pad ? ST_PUT : ST_DONE;
            end
            ST_BACK:  n_state = ST_DONE;
            ST_MOD: begin
                if (r_step == 4'(MOD_STEPS - 1)) n_state = ST_ADDR;
            end
            ST_ADDR:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and RAM controls
    always_comb begin
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_top       = r_top;
        n_clr       = r_clr;
        n_fcnt      = r_fcnt;
        n_step      = r_step;
        n_req       = r_req;
        n_ch        = r_ch;
        n_rgb       = r_rgb;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cell      = r_cell;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        mem_we      = 1'b0;
        mem_waddr   = r_cursor;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = addr_wrap[PW-1:0];
        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            // Sweep null cells in black through the store
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + PW'(1);
            end
            // Capture the transaction
            ST_IDLE: begin
                if (in_fire) begin
                    n_req  = t_req'(s_axis_tuser);
                    n_ch   = s_axis_tdata[7:0];
                    n_rgb  = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
                    n_rem  = s_axis_tdata[43:32];
                    n_div  = DIV_INIT;
                    n_step = '0;
                    n_cell = '0;
                end
            end
            // Store one character (a space when padding an end line) at the cursor and advance
            ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cursor;
                mem_wdata = {(r_req == REQ_WRITE) ? r_ch : SPACE_CHAR, r_rgb};
                n_cursor  = cur_inc;
                n_col     = col_inc;
                n_fcnt    = '0;
            end
            // Blank the top row, then move the top line down
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_top + PW'(r_fcnt);
                mem_wdata = {SPACE_CHAR, r_rgb};
                n_fcnt    = r_fcnt + CW'(1);
                if (r_fcnt == LAST_COL) n_top = top_inc;
            end
            // Step back and store a null character
            ST_BACK: begin
                mem_we    = 1'b1;
                mem_waddr = cur_dec;
                mem_wdata = {NULL_CHAR, r_rgb};
                n_cursor  = cur_dec;
                n_col     = col_dec;
            end
            // One compare-subtract step of index modulo cell count
            ST_MOD: begin
                if (rem_ext >= r_div) n_rem = INDEX_W'(rem_ext - r_div);
                n_div  = r_div >> 1;
                n_step = r_step + 4'd1;
            end
            // Issue the cell read
            ST_ADDR: begin
                mem_re = 1'b1;
            end
            ST_RDATA: begin
                n_cell = mem_rdata;
            end
            // Hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {INDEX_W'(r_top), INDEX_W'(r_cursor),
                                   r_cell[7:0], r_cell[15:8], r_cell[23:16],
                                   r_cell[31:24]};
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cursor    <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_clr       <= '0;
            r_fcnt      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_top       <= n_top;
            r_clr       <= n_clr;
            r_fcnt      <= n_fcnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_ch       <= n_ch;
        r_rgb      <= n_rgb;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cell     <= n_cell;
        r_out_data <= n_out_data;
    end

    // Cell store
    scb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CC)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

### design/scb_ram.sv
// ============================================================================
// scb_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module scb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 3600
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
